FILE: hw/rtl/upc_pkg.sv
// Shared types, constants and character helpers for the URL percent codec.
// Used by upc_front, upc_queue, upc_back and url_percent_codec; no dependencies.
package upc_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_PASS = 2'd0;
  localparam logic [1:0] CMD_HEX  = 2'd1;
  localparam logic [1:0] CMD_BAD  = 2'd2;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_alnum(input logic [7:0] b);
    is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // Bit 4 flags a valid hex digit; bits 3:0 carry its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
      hex_nibble = {1'b1, v[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
      hex_nibble = {1'b1, v[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
      hex_nibble = {1'b1, v[3:0]};
    end else begin
      hex_nibble = 5'd0;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_char = 8'h30 + {4'd0, n};
    end else begin
      hex_char = 8'h37 + {4'd0, n};
    end
  endfunction

endpackage

FILE: hw/rtl/upc_front.sv
// Front end of the URL percent codec: holds the mode register and escape state,
// and classifies each accepted byte into a command for the queue. Uses upc_pkg.
module upc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          msg_last,
  output logic          q_push,
  output upc_pkg::cmd_t q_cmd
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic       decode_mode;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] first_digit;
  logic       emit;
  logic [4:0] hi_nib;
  logic [4:0] lo_nib;
  logic       plain_emit;
  logic [7:0] plain_byte;
  logic       plain_pct;

  assign hi_nib = upc_pkg::hex_nibble(first_digit);
  assign lo_nib = upc_pkg::hex_nibble(in_byte);

  always_comb begin
    plain_emit = 1'b0;
    plain_byte = in_byte;
    plain_pct  = 1'b0;
    if (upc_pkg::is_alnum(in_byte) || in_byte == upc_pkg::CH_DASH ||
        in_byte == upc_pkg::CH_USCR || in_byte == upc_pkg::CH_DOT) begin
      plain_emit = 1'b1;
    end else if (in_byte == upc_pkg::CH_PLUS) begin
      plain_emit = 1'b1;
      plain_byte = upc_pkg::CH_SPACE;
    end else if (in_byte == upc_pkg::CH_PCT && !msg_last) begin
      plain_pct = 1'b1;
    end
  end

  always_comb begin
    emit        = 1'b0;
    q_cmd.kind  = upc_pkg::CMD_PASS;
    q_cmd.data  = in_byte;
    q_cmd.last  = msg_last;
    phase_next  = PH_IDLE;
    if (!decode_mode) begin
      emit = 1'b1;
      if (!(upc_pkg::is_alnum(in_byte) || in_byte == upc_pkg::CH_DASH ||
            in_byte == upc_pkg::CH_USCR || in_byte == upc_pkg::CH_TILDE ||
            in_byte == upc_pkg::CH_DOT)) begin
        q_cmd.kind = upc_pkg::CMD_HEX;
      end
    end else begin
      unique case (phase)
        PH_PCT: begin
          if (msg_last) begin
            emit       = plain_emit;
            q_cmd.data = plain_byte;
          end else begin
            phase_next = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          emit = 1'b1;
          if (hi_nib[4] && lo_nib[4]) begin
            q_cmd.data = {hi_nib[3:0], lo_nib[3:0]};
          end else begin
            q_cmd.kind = upc_pkg::CMD_BAD;
            q_cmd.data = 8'h00;
          end
        end
        default: begin
          emit       = plain_emit;
          q_cmd.data = plain_byte;
          if (plain_pct) begin
            phase_next = PH_PCT;
          end
        end
      endcase
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      phase       <= PH_IDLE;
    end else if (cfg_write) begin
      decode_mode <= cfg_data;
      phase       <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && decode_mode && phase == PH_PCT && !msg_last) begin
      first_digit <= in_byte;
    end
  end

endmodule

FILE: hw/rtl/upc_queue.sv
// Short command queue between the front and back ends of the URL percent codec.
// Register-based ring of upc_pkg::QDEPTH entries. Uses upc_pkg.
module upc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  upc_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output upc_pkg::cmd_t    head,
  output upc_pkg::q_stat_t stat
);

  upc_pkg::cmd_t                  mem [upc_pkg::QDEPTH];
  logic [upc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [upc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [upc_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign stat.full  = (count == upc_pkg::QCNT_W'(upc_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == upc_pkg::QPTR_W'(upc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == upc_pkg::QPTR_W'(upc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/upc_back.sv
// Back end of the URL percent codec: expands queued commands into result bytes
// and holds them in the output register until popped. Uses upc_pkg.
module upc_back (
  input  logic          clk,
  input  logic          rst,
  input  upc_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          msg_end,
  output logic          bad_escape
);

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic       final_byte;
  logic [7:0] byte_sel;
  logic       bad_sel;

  always_comb begin
    byte_sel   = head.data;
    bad_sel    = 1'b0;
    final_byte = 1'b1;
    unique case (head.kind)
      upc_pkg::CMD_HEX: begin
        final_byte = (idx == 2'd2);
        unique case (idx)
          2'd0:    byte_sel = upc_pkg::CH_PCT;
          2'd1:    byte_sel = upc_pkg::hex_char(head.data[7:4]);
          default: byte_sel = upc_pkg::hex_char(head.data[3:0]);
        endcase
      end
      upc_pkg::CMD_BAD: begin
        byte_sel = 8'h00;
        bad_sel  = 1'b1;
      end
      default: begin
        byte_sel = head.data;
      end
    endcase
  end

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= byte_sel;
      run_last   <= final_byte;
      msg_end    <= final_byte && head.last;
      bad_escape <= bad_sel;
    end
  end

endmodule

FILE: hw/rtl/url_percent_codec.sv
// Top level of the URL percent codec: front end, command queue and back end.
// Depends on upc_pkg, upc_front, upc_queue and upc_back.
//
// Usage: message bytes enter through a queue-style port (push, full, in_byte,
// msg_last); a byte is taken at an edge with push high and full low. Results
// leave through a queue-style port (empty, pop, out_byte, run_last, msg_end,
// bad_escape); the oldest result is shown while empty is low and leaves at an
// edge with pop high. The user sets the mode through cfg_valid/cfg_ready/
// cfg_data only while the block is idle, which the block does not enforce;
// a write also clears any pending escape. Each command passes the queue,
// then the single output register. Results leave at one byte per cycle
// while the receiver pops; an escaped byte in encode mode gives three result
// bytes, any other byte at most one. Input transfers continue each cycle
// while the four-entry command queue has room. Reset clears the mode to
// encode, the escape state, the queue and the output register. When the
// receiver stalls, the output holds, the queue fills and full rises.
module url_percent_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       msg_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       msg_end,
  output logic       bad_escape
);

  upc_pkg::cmd_t    q_cmd;
  upc_pkg::cmd_t    q_head;
  upc_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;
  assign accept    = push && !q_stat.full;

  upc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .msg_last  (msg_last),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  upc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  upc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_stat.empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .msg_end    (msg_end),
    .bad_escape (bad_escape)
  );

  a_msg_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    !empty && msg_end |-> run_last)
    else $error("msg_end shown on a result that does not close its run");

  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    !empty && bad_escape |-> run_last && out_byte == 8'h00)
    else $error("bad escape result is not a single zero byte");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_push)
    else $error("command pushed into a full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_codec: encode and decode mode traffic.
// Depends on upc_pkg for character constants and on the url_percent_codec RTL.
module tb;

  localparam bit MODE_ENCODE = 1'b0;
  localparam bit MODE_DECODE = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;

  typedef enum logic [1:0] {ESC_NONE, ESC_PERCENT, ESC_FIRST} esc_state_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       msg_close;
    logic       bad;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       msg_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       msg_end;
  logic       bad_escape;

  msg_byte_t  tx_bytes[$];
  msg_byte_t  tx_next;
  result_t    expected_out[$];

  bit         codec_mode = MODE_ENCODE;
  esc_state_t esc = ESC_NONE;
  logic [7:0] held_digit = 8'h00;

  bit quiet = 1'b0;
  int tx_gap = 0;
  int rx_stall = 0;
  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int bad_seen = 0;
  int cfg_writes = 0;

  url_percent_codec DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full), .in_byte(in_byte), .msg_last(msg_last),
    .empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
    .msg_end(msg_end), .bad_escape(bad_escape)
  );

  always #6 clk = ~clk;

  function automatic bit is_alnum_byte(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return -1;
  endfunction

  // Returns a plain input's decoded byte, or -1 if dropped or opening an escape.
  function automatic int plain_decoded(logic [7:0] b, bit last);
    if (is_alnum_byte(b) || b == upc_pkg::CH_DASH || b == upc_pkg::CH_USCR ||
        b == upc_pkg::CH_DOT) return int'(b);
    if (b == upc_pkg::CH_PLUS) return int'(upc_pkg::CH_SPACE);
    if (b == upc_pkg::CH_PCT && !last) esc = ESC_PERCENT;
    return -1;
  endfunction

  function automatic void codec_predict(logic [7:0] b, bit last);
    string      digits;
    logic [7:0] outs[$];
    bit         bad;
    int         v;
    int         hi;
    int         lo;
    result_t    r;
    digits = "0123456789ABCDEF";
    bad = 1'b0;
    if (codec_mode == MODE_ENCODE) begin
      esc = ESC_NONE;
      if (is_alnum_byte(b) || b == upc_pkg::CH_DASH || b == upc_pkg::CH_USCR ||
          b == upc_pkg::CH_TILDE || b == upc_pkg::CH_DOT) begin
        outs = {outs, b};
      end else begin
        outs = {outs, upc_pkg::CH_PCT};
        outs = {outs, 8'(digits[b[7:4]])};
        outs = {outs, 8'(digits[b[3:0]])};
      end
    end else if (esc == ESC_PERCENT) begin
      esc = ESC_NONE;
      if (last) begin
        v = plain_decoded(b, 1'b1);
        if (v >= 0) outs = {outs, v[7:0]};
      end else begin
        held_digit = b;
        esc = ESC_FIRST;
      end
    end else if (esc == ESC_FIRST) begin
      esc = ESC_NONE;
      hi = hex_val(held_digit);
      lo = hex_val(b);
      if (hi < 0 || lo < 0) begin
        bad = 1'b1;
        outs = {outs, 8'h00};
      end else begin
        v = hi * 16 + lo;
        outs = {outs, v[7:0]};
      end
    end else begin
      v = plain_decoded(b, last);
      if (v >= 0) outs = {outs, v[7:0]};
    end
    if (last) esc = ESC_NONE;
    foreach (outs[i]) begin
      r.data = outs[i];
      r.run_end = (i == outs.size() - 1);
      r.msg_close = r.run_end && last;
      r.bad = bad;
      expected_out = {expected_out, r};
    end
  endfunction

  function automatic void add_byte(logic [7:0] b, bit last);
    msg_byte_t m;
    m.b = b;
    m.last = last;
    tx_bytes = {tx_bytes, m};
  endfunction

  function automatic void add_text(string s, bit close_msg);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], close_msg && (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return 8'("0" + $urandom_range(0, 9));
      1: return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  function automatic void add_decode_msg();
    logic [7:0] bytes[$];
    int         tokens;
    int         sel;
    logic [7:0] punct[4];
    punct = '{upc_pkg::CH_DASH, upc_pkg::CH_USCR, upc_pkg::CH_DOT, upc_pkg::CH_PLUS};
    tokens = $urandom_range(1, 6);
    for (int k = 0; k < tokens; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
        bytes = {bytes, rand_alnum()};
      end else if (sel < 10) begin
        bytes = {bytes, punct[$urandom_range(0, 3)]};
      end else if (sel < 16) begin
        bytes = {bytes, upc_pkg::CH_PCT};
        bytes = {bytes, rand_hex_char()};
        bytes = {bytes, rand_hex_char()};
      end else if (sel == 16) begin
        bytes = {bytes, 8'($urandom_range(0, 255))};
      end else if (sel == 17) begin
        bytes = {bytes, upc_pkg::CH_PCT};
        bytes = {bytes, 8'($urandom_range(0, 255))};
        bytes = {bytes, 8'($urandom_range(0, 255))};
      end else if (sel == 18) begin
        bytes = {bytes, upc_pkg::CH_PCT};
        bytes = {bytes, rand_hex_char()};
        bytes = {bytes, 8'("g" + $urandom_range(0, 19))};
      end else begin
        bytes = {bytes, ($urandom_range(0, 1) ? upc_pkg::CH_TILDE : upc_pkg::CH_SPACE)};
      end
    end
    case ($urandom_range(0, 9))
      0: bytes = {bytes, upc_pkg::CH_PCT};
      1: begin
        bytes = {bytes, upc_pkg::CH_PCT};
        bytes = {bytes, ($urandom_range(0, 1) ? rand_alnum() : upc_pkg::CH_PLUS)};
      end
      default: ;
    endcase
    foreach (bytes[i]) add_byte(bytes[i], i == bytes.size() - 1);
  endfunction

  function automatic void add_encode_msg();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      add_byte($urandom_range(0, 2) == 0 ? rand_alnum() : 8'($urandom_range(0, 255)),
               i == len - 1);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %0s at result %0d: got 0x%0h, want 0x%0h",
             what, results_checked, got, want);
    errors++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_out.size() == 0) begin
      report_mismatch("unexpected result", int'(out_byte), 0);
    end else begin
      want = expected_out.pop_front();
      if (bad_escape !== want.bad)
        report_mismatch("bad_escape", int'(bad_escape), int'(want.bad));
      if (out_byte !== want.data)
        report_mismatch("out_byte", int'(out_byte), int'(want.data));
      if (run_last !== want.run_end)
        report_mismatch("run_last", int'(run_last), int'(want.run_end));
      if (msg_end !== want.msg_close)
        report_mismatch("msg_end", int'(msg_end), int'(want.msg_close));
      if (want.bad) bad_seen++;
    end
    results_checked++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (tx_bytes.size() != 0 || push || expected_out.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    codec_mode = m;
    esc = ESC_NONE;
    cfg_writes++;
  endtask

  task automatic fill_random(bit decode, int count);
    int target;
    target = tx_bytes.size() + count;
    while (tx_bytes.size() < target) begin
      if (decode) add_decode_msg();
      else add_encode_msg();
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("url_percent_codec test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        codec_predict(in_byte, msg_last);
        bytes_sent++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        push <= 1'b0;
      end else if (tx_bytes.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
        tx_gap <= $urandom_range(0, 8);
        push <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        tx_next = tx_bytes.pop_front();
        push <= 1'b1;
        in_byte <= tx_next.b;
        msg_last <= tx_next.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_stall <= $urandom_range(0, 8);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Encode straight after reset, then an explicit write of the same mode.
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_text("azAZ09-_~. %+/", 1'b1);
    wait_idle();
    write_mode(MODE_ENCODE);
    add_text("a~%", 1'b1);
    wait_idle();

    // Decode corner cases, ending on an escape left open across a mode write.
    write_mode(MODE_DECODE);
    add_text("a%41%4a+", 1'b0);
    add_text("%zz%4g", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("~", 1'b1);
    add_text("%", 1'b1);
    add_text("%A", 1'b1);
    add_text("%+", 1'b1);
    add_text("x%", 1'b0);
    wait_idle();
    write_mode(MODE_DECODE);
    add_text("41", 1'b1);
    fill_random(1'b1, 90);
    add_byte(upc_pkg::CH_PCT, 1'b0);
    wait_idle();

    write_mode(MODE_ENCODE);
    fill_random(1'b0, 55);
    wait_idle();

    // The closing part runs with neither side idling.
    write_mode(MODE_DECODE);
    quiet = 1'b1;
    fill_random(1'b1, 50);
    add_text("%3", 1'b0);
    wait_idle();
    write_mode(MODE_ENCODE);
    fill_random(1'b0, 15);
    wait_idle();

    if (expected_out.size() != 0) begin
      $display("%0d expected results never arrived.", expected_out.size());
      errors++;
    end
    $display("Sent %0d message bytes in both modes across %0d mode writes.",
             bytes_sent, cfg_writes);
    $display("Checked %0d result bytes, %0d of them bad escapes; %0d mismatches.",
             results_checked, bad_seen, errors);
    if (errors == 0) begin
      $display("url_percent_codec test passed");
    end else begin
      $display("url_percent_codec test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/upc_pkg.sv
hw/rtl/upc_front.sv
hw/rtl/upc_queue.sv
hw/rtl/upc_back.sv
hw/rtl/url_percent_codec.sv
tb/sv/tb.sv
